>>> sv/scale_tap_gesture_detector_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tap gesture detector
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SCALE_TAP_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define SCALE_TAP_GESTURE_DETECTOR_TOP_ASSERT_SVH

// same-cycle implication
`define STGD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STGD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/stgd_pkg.sv
// ---------------------------------------------------------------------------
// stgd_pkg
// Types and constants shared by the tap gesture detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stgd_pkg;

	localparam int HIST_DEPTH_DEF = 5;

	localparam int WGT_W      = 24;
	localparam int TIME_W     = 32;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 15;

	localparam logic [TIME_W-1:0] STORE_INTERVAL_MS = 32'd100;
	localparam int                SLOPE_CG          = 200;
	localparam int                STEADY_RANGE_CG   = 50;
	localparam logic [THR_W-1:0]  CG_PER_G          = 15'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PEAK_HEIGHT = 3'd0,
		CFG_WINDOW      = 3'd1,
		CFG_GESTURE_EN  = 3'd2,
		CFG_TARE_EN     = 3'd3,
		CFG_TIMER_EN    = 3'd4
	} cfg_idx_t;

	localparam logic [THR_W-1:0] PEAK_THR_RST  = 15'd1500;
	localparam logic [15:0]      WINDOW_RST    = 16'd400;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 3'd0,
		ACT_TARE    = 3'd1,
		ACT_TSTART  = 3'd2,
		ACT_TSTOP   = 3'd3,
		ACT_TRESET  = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_DIV,
		ST_EVAL,
		ST_PUSH
	} stgd_state_t;

endpackage

>>> sv/stgd_in_if.sv
// ---------------------------------------------------------------------------
// stgd_in_if
// Sample channel: weight, timestamp and timer capability.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stgd_in_if import stgd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WGT_W-1:0]  weight_cg;
	logic [TIME_W-1:0]        time_ms;
	logic                     scale_has_timer;

	modport source (output valid, output weight_cg, output time_ms,
		output scale_has_timer, input ready);
	modport sink (input valid, input weight_cg, input time_ms,
		input scale_has_timer, output ready);
endinterface

>>> sv/stgd_out_if.sv
// ---------------------------------------------------------------------------
// stgd_out_if
// Result channel: one action word per sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stgd_out_if import stgd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;

	modport source (output valid, output action, input ready);
	modport sink (input valid, input action, output ready);
endinterface

>>> sv/stgd_ram.sv
// ---------------------------------------------------------------------------
// stgd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stgd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 5,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/scale_tap_gesture_detector_top.sv
// ---------------------------------------------------------------------------
// scale_tap_gesture_detector_top
// Tap gesture detector on timestamped scale weight samples; history in RAM.
// ---------------------------------------------------------------------------
//  channel   dir   word
//  weight    in    weight_cg[23:0] s, time_ms[31:0], scale_has_timer
//  gesture   out   action[2:0]
//  cfg_*     in    write only: cfg_we, cfg_index, cfg_data[15:0]
//
//  A sample passes accept, write, evaluate and push when it is not stored or
//  the history is not yet full; a stored sample with a full history also
//  scans the RAM first (one read per cycle), and a steady history adds the
//  baseline steps (reciprocal multiply, then sign) before the evaluation.
//  One sample in flight; a result may wait in the output register while
//  the next sample is taken. Reset clears the control and detector state; the RAM needs no clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scale_tap_gesture_detector_top_assert.svh"

module scale_tap_gesture_detector_top import stgd_pkg::*; #(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	stgd_in_if.sink               weight,
	stgd_out_if.source            gesture
);

	localparam int IDX_W     = $clog2(HISTORY_DEPTH);
	localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W     = WGT_W + IDX_W;
	localparam int DIV_STEPS = 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
	localparam int DIFF_W    = WGT_W + 1;
	localparam int REC_SH    = SUM_W - 1 + IDX_W;
	localparam int PROD_W    = SUM_W + REC_SH;

	localparam longint REC_M_L = ((longint'(1) << REC_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HISTORY_DEPTH - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [REC_SH-1:0] REC_M     = REC_SH'(REC_M_L);
	localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

	localparam logic signed [DIFF_W-1:0] SLOPE_P  = DIFF_W'(SLOPE_CG);
	localparam logic signed [DIFF_W-1:0] SLOPE_N  = -DIFF_W'(SLOPE_CG);
	localparam logic signed [DIFF_W-1:0] STEADY_R = DIFF_W'(STEADY_RANGE_CG);

	stgd_state_t state_q, state_d;

	// configuration
	logic [THR_W-1:0] peak_thr_q;
	logic [15:0]      window_q;
	logic             gest_en_q, tare_en_q, timer_en_q;

	// captured sample
	logic signed [WGT_W-1:0] w_q;
	logic [TIME_W-1:0]       now_q;
	logic                    has_timer_q;

	// detector state
	logic [IDX_W-1:0]        idx_q;
	logic [FILL_W-1:0]       fill_q;
	logic [TIME_W-1:0]       last_store_q;
	logic signed [WGT_W-1:0] base_q;
	logic signed [WGT_W-1:0] prev_q;
	logic                    rising_q;
	logic [TIME_W-1:0]       last_peak_q;
	logic [1:0]              peak_cnt_q;
	logic                    dec_pend_q;
	logic [TIME_W-1:0]       dec_start_q;
	logic [1:0]              phase_q;

	// scan
	logic [FILL_W-1:0]       scan_cnt_q;
	logic                    rd_vld_s1, rd_first_s1, rd_last_s1;
	logic signed [SUM_W-1:0] sum_q, sum_n;
	logic signed [WGT_W-1:0] lo_q, hi_q, lo_n, hi_n;
	logic signed [WGT_W-1:0] ram_rdata;
	logic [WGT_W-1:0]        ram_rraw;
	logic                    scan_issue, scan_done, steady;

	// baseline division
	logic [SUM_W-1:0]  mag_q;
	logic [PROD_W-1:0] prod;
	logic [WGT_W-1:0]  quot_q, quot_signed;
	logic              neg_q;
	logic [DCNT_W-1:0] div_cnt_q;

	// evaluation
	logic                     store, ram_we, hist_ready;
	logic signed [DIFF_W-1:0] step_diff, height;
	logic                     rise, fall, peak_ok, in_win, triple, expire;
	logic                     timer_go;
	act_t                     timer_act, act_d, act_q;
	logic [1:0]               phase_next;

	// output register
	logic       out_vld_q;
	logic [2:0] out_act_q;

	stgd_ram #(.WIDTH(WGT_W), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (w_q),
		.raddr (scan_cnt_q[IDX_W-1:0]),
		.rdata (ram_rraw)
	);

	assign ram_rdata = $signed(ram_rraw);

	assign store      = (now_q - last_store_q) >= STORE_INTERVAL_MS;
	assign ram_we     = (state_q == ST_WRITE) && store;
	assign scan_issue = (state_q == ST_SCAN) && (scan_cnt_q < FILL_FULL);
	assign scan_done  = rd_vld_s1 && rd_last_s1;

	always_comb begin
		if (rd_first_s1) begin
			sum_n = SUM_W'(ram_rdata);
			lo_n  = ram_rdata;
			hi_n  = ram_rdata;
		end else begin
			sum_n = sum_q + SUM_W'(ram_rdata);
			lo_n  = (ram_rdata < lo_q) ? ram_rdata : lo_q;
			hi_n  = (ram_rdata > hi_q) ? ram_rdata : hi_q;
		end
		steady = (DIFF_W'(hi_n) - DIFF_W'(lo_n)) < STEADY_R;
	end

	// |sum| / depth by reciprocal multiply, exact for |sum| <= 2^(SUM_W-1)
	assign prod        = PROD_W'(mag_q) * PROD_W'(REC_M);
	assign quot_signed = neg_q ? (~quot_q + 1'b1) : quot_q;

	always_comb begin
		hist_ready = (fill_q == FILL_FULL);
		step_diff  = DIFF_W'(w_q) - DIFF_W'(prev_q);
		height     = DIFF_W'(prev_q) - DIFF_W'(base_q);
		rise       = hist_ready && (step_diff > SLOPE_P);
		fall       = !rise && (step_diff < SLOPE_N) && rising_q;
		peak_ok    = fall && hist_ready &&
			(height > $signed({{(DIFF_W-THR_W){1'b0}}, peak_thr_q}));
		in_win     = (now_q - last_peak_q) < {16'd0, window_q};
		triple     = peak_ok && in_win && (peak_cnt_q == 2'd2);
		expire     = dec_pend_q && !(peak_ok && in_win) &&
			((now_q - dec_start_q) >= {16'd0, window_q});
		timer_go   = triple && gest_en_q && timer_en_q && has_timer_q;
		unique case (phase_q)
			2'd0: begin
				timer_act  = ACT_TSTART;
				phase_next = 2'd1;
			end
			2'd1: begin
				timer_act  = ACT_TSTOP;
				phase_next = 2'd2;
			end
			2'd2: begin
				timer_act  = ACT_TRESET;
				phase_next = 2'd0;
			end
			default: begin
				timer_act  = ACT_TRESET;
				phase_next = 2'd1;
			end
		endcase
		priority if (expire && gest_en_q && tare_en_q) begin
			act_d = ACT_TARE;
		end else if (timer_go) begin
			act_d = timer_act;
		end else begin
			act_d = ACT_NONE;
		end
	end

	always_comb begin
		state_d      = state_q;
		weight.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				weight.ready = 1'b1;
				if (weight.valid) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (store && (fill_q >= FILL_LAST)) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = steady ? ST_DIV : ST_EVAL;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DCNT_LAST) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!out_vld_q || gesture.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign gesture.valid  = out_vld_q;
	assign gesture.action = out_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_thr_q   <= PEAK_THR_RST;
			window_q     <= WINDOW_RST;
			gest_en_q    <= 1'b0;
			tare_en_q    <= 1'b1;
			timer_en_q   <= 1'b1;
			idx_q        <= '0;
			fill_q       <= '0;
			last_store_q <= '0;
			base_q       <= '0;
			prev_q       <= '0;
			rising_q     <= 1'b0;
			last_peak_q  <= '0;
			peak_cnt_q   <= '0;
			dec_pend_q   <= 1'b0;
			dec_start_q  <= '0;
			phase_q      <= '0;
			scan_cnt_q   <= '0;
			rd_vld_s1    <= 1'b0;
			div_cnt_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PEAK_HEIGHT: peak_thr_q <= {7'd0, cfg_data[7:0]} * CG_PER_G;
					CFG_WINDOW:      window_q   <= cfg_data;
					CFG_GESTURE_EN:  gest_en_q  <= cfg_data[0];
					CFG_TARE_EN:     tare_en_q  <= cfg_data[0];
					CFG_TIMER_EN:    timer_en_q <= cfg_data[0];
					default: ;
				endcase
			end

			rd_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end

			if (ram_we) begin
				last_store_q <= now_q;
				idx_q        <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == ST_WRITE) begin
				scan_cnt_q <= '0;
				div_cnt_q  <= '0;
			end

			if (state_q == ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DCNT_LAST) begin
					base_q <= $signed(quot_signed);
				end
			end

			if (state_q == ST_EVAL) begin
				prev_q <= w_q;
				if (rise) begin
					rising_q <= 1'b1;
				end else if (fall) begin
					rising_q <= 1'b0;
				end
				if (peak_ok) begin
					last_peak_q <= now_q;
					if (!in_win) begin
						peak_cnt_q <= 2'd1;
					end else if (triple) begin
						peak_cnt_q <= 2'd0;
						dec_pend_q <= 1'b0;
					end else begin
						peak_cnt_q  <= peak_cnt_q + 1'b1;
						dec_pend_q  <= 1'b1;
						dec_start_q <= now_q;
					end
				end
				if (expire) begin
					dec_pend_q <= 1'b0;
					peak_cnt_q <= 2'd0;
				end
				if (timer_go) begin
					phase_q <= phase_next;
				end
			end

			if (state_q == ST_PUSH && (!out_vld_q || gesture.ready)) begin
				out_vld_q <= 1'b1;
			end else if (gesture.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (weight.valid && weight.ready) begin
			w_q         <= weight.weight_cg;
			now_q       <= weight.time_ms;
			has_timer_q <= weight.scale_has_timer;
		end
		rd_first_s1 <= (scan_cnt_q == '0);
		rd_last_s1  <= (scan_cnt_q == FILL_LAST);
		if (rd_vld_s1) begin
			sum_q <= sum_n;
			lo_q  <= lo_n;
			hi_q  <= hi_n;
		end
		if (state_q == ST_SCAN && scan_done) begin
			neg_q <= sum_n[SUM_W-1];
			mag_q <= sum_n[SUM_W-1] ? SUM_W'(-sum_n) : SUM_W'(sum_n);
		end
		if (state_q == ST_DIV && div_cnt_q == '0) begin
			quot_q <= prod[REC_SH +: WGT_W];
		end
		if (state_q == ST_EVAL) begin
			act_q <= act_d;
		end
		if (state_q == ST_PUSH && (!out_vld_q || gesture.ready)) begin
			out_act_q <= act_q;
		end
	end

	`STGD_ASSERT_IMP(a_push_source, $rose(out_vld_q), $past(state_q) == ST_PUSH,
		"result raised outside push")
	`STGD_ASSERT_IMP(a_scan_full, state_q == ST_SCAN, fill_q == FILL_FULL,
		"history scan with partial fill")
	`STGD_ASSERT_IMP(a_tare_pending, state_q == ST_EVAL && act_d == ACT_TARE, dec_pend_q,
		"tare without open decision")
	`STGD_ASSERT_NXT(a_accept_write, weight.valid && weight.ready, state_q == ST_WRITE,
		"accepted word not processed")

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Checks the tap gesture detector against a cycle-free action tracker.
// Samples go in through a queue-fed driver, actions are taken by a stalling
// receiver and compared in order with the tracker's prediction. Directed
// taps first, then phases of random tap sequences under changing settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import stgd_pkg::*; ();

	localparam int     DEPTH      = HIST_DEPTH_DEF;
	localparam longint CG_SCALE   = 100;
	localparam int     RAND_ITEMS = 1250;
	localparam int     HOLD_CYC   = 160;

	typedef struct packed {
		logic signed [WGT_W-1:0] weight_cg;
		logic [TIME_W-1:0]       time_ms;
		logic                    scale_has_timer;
	} sample_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stgd_in_if  weight_ch ();
	stgd_out_if gesture_ch ();

	scale_tap_gesture_detector_top #(
		.HISTORY_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.weight   (weight_ch),
		.gesture  (gesture_ch)
	);

	// tracker settings
	logic [7:0]  c_peak;
	logic [15:0] c_win;
	bit          c_gest, c_tare, c_timer;

	// tracker state
	logic signed [WGT_W-1:0] hist_cg [DEPTH];
	int unsigned             h_idx, h_fill;
	logic [TIME_W-1:0]       last_store, last_peak, dec_start;
	logic signed [WGT_W-1:0] base_cg, prev_cg;
	bit                      rising, dec_open;
	int unsigned             peaks;
	logic [1:0]              tmr_phase;

	sample_t samples_to_send[$];
	act_t    pending_actions[$];
	sample_t drv_word;
	act_t    want;

	logic [TIME_W-1:0] t_now;
	int  src_gap, rx_wait, rx_draw;
	bit  src_calm, rx_calm, rx_hold;
	int  n_pushed, n_taken, n_results, n_errors, n_tare, n_timer, n_phases;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic act_t next_action(input sample_t s);
		longint            w, v, lo, hi, sum, height;
		logic [TIME_W-1:0] now;
		bit                full;
		act_t              a;
		w   = $signed(s.weight_cg);
		now = s.time_ms;
		a   = ACT_NONE;
		if (now - last_store >= STORE_INTERVAL_MS) begin
			last_store       = now;
			hist_cg[h_idx]   = s.weight_cg;
			h_idx            = (h_idx + 1) % DEPTH;
			if (h_fill < DEPTH)
				h_fill++;
			if (h_fill >= DEPTH) begin
				lo  = hist_cg[0];
				hi  = hist_cg[0];
				sum = 0;
				foreach (hist_cg[i]) begin
					v = hist_cg[i];
					if (v < lo) lo = v;
					if (v > hi) hi = v;
					sum += v;
				end
				if (hi - lo < STEADY_RANGE_CG)
					base_cg = WGT_W'(sum / DEPTH);
			end
		end
		full = h_fill >= DEPTH;
		if (full && w > longint'(prev_cg) + SLOPE_CG) begin
			rising = 1'b1;
		end else if (w < longint'(prev_cg) - SLOPE_CG && rising) begin
			height = longint'(prev_cg) - longint'(base_cg);
			rising = 1'b0;
			if (full && height > longint'(c_peak) * CG_SCALE) begin
				if (now - last_peak < c_win) begin
					peaks++;
					if (peaks >= 3) begin
						dec_open = 1'b0;
						peaks    = 0;
						if (c_gest && c_timer && s.scale_has_timer) begin
							case (tmr_phase)
								2'd0: a = ACT_TSTART;
								2'd1: a = ACT_TSTOP;
								default: a = ACT_TRESET;
							endcase
							tmr_phase = 2'((int'(tmr_phase) + 1) % 3);
						end
					end else begin
						dec_open  = 1'b1;
						dec_start = now;
					end
				end else begin
					peaks = 1;
				end
				last_peak = now;
			end
		end
		prev_cg = s.weight_cg;
		if (dec_open && now - dec_start >= c_win) begin
			dec_open = 1'b0;
			peaks    = 0;
			if (c_gest && c_tare)
				a = ACT_TARE;
		end
		return a;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		n_errors++;
		$display("tb_top: MISMATCH %s: got %0d, expected %0d (result %0d)",
			what, got, exp_val, n_results);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			weight_ch.valid <= 1'b0;
			src_gap <= 0;
		end else if (!weight_ch.valid || weight_ch.ready) begin
			if (src_gap != 0) begin
				weight_ch.valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (samples_to_send.size() != 0) begin
				drv_word = samples_to_send.pop_front();
				weight_ch.valid           <= 1'b1;
				weight_ch.weight_cg       <= drv_word.weight_cg;
				weight_ch.time_ms         <= drv_word.time_ms;
				weight_ch.scale_has_timer <= drv_word.scale_has_timer;
				src_gap <= src_calm ? 0 : $urandom_range(0, 4);
			end else begin
				weight_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) begin
			gesture_ch.ready <= 1'b0;
			rx_wait <= 0;
		end else if (rx_hold) begin
			gesture_ch.ready <= 1'b0;
		end else if (gesture_ch.valid && gesture_ch.ready) begin
			rx_draw = rx_calm ? 0 : $urandom_range(0, 4);
			gesture_ch.ready <= (rx_draw == 0);
			rx_wait <= rx_draw;
		end else if (rx_wait > 0) begin
			gesture_ch.ready <= (rx_wait == 1);
			rx_wait <= rx_wait - 1;
		end else begin
			gesture_ch.ready <= 1'b1;
		end
	end

	// monitor: results first, then the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (gesture_ch.valid && gesture_ch.ready) begin
				n_results++;
				if (pending_actions.size() == 0) begin
					report_mismatch("action with nothing expected", gesture_ch.action, 0);
				end else begin
					want = pending_actions.pop_front();
					if (gesture_ch.action !== want)
						report_mismatch("action", gesture_ch.action, want);
					if (want == ACT_TARE)
						n_tare++;
					else if (want != ACT_NONE)
						n_timer++;
				end
			end
			if (weight_ch.valid && weight_ch.ready) begin
				pending_actions.push_back(next_action({weight_ch.weight_cg,
					weight_ch.time_ms, weight_ch.scale_has_timer}));
				n_taken++;
			end
		end
	end

	// long receiver hold-offs so the block backs up into its input
	initial begin
		rx_hold = 1'b0;
		while (n_taken < 400)
			@(negedge clk);
		@(posedge clk) rx_hold <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		rx_hold <= 1'b0;
		while (n_taken < 900)
			@(negedge clk);
		@(posedge clk) rx_hold <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#(10_000_000);
		$display("tb_top: timeout, %0d samples taken, %0d actions seen", n_taken, n_results);
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic push_sample(input int w, input int unsigned dt, input bit tmr);
		sample_t s;
		t_now += dt;
		s.weight_cg       = w[WGT_W-1:0];
		s.time_ms         = t_now;
		s.scale_has_timer = tmr;
		samples_to_send.push_back(s);
		n_pushed++;
	endtask

	task automatic push_at(input int w, input logic [TIME_W-1:0] t, input bit tmr);
		t_now = t;
		push_sample(w, 0, tmr);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || weight_ch.valid || pending_actions.size() != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PEAK_HEIGHT: c_peak  = val[7:0];
			CFG_WINDOW:      c_win   = val;
			CFG_GESTURE_EN:  c_gest  = val[0];
			CFG_TARE_EN:     c_tare  = val[0];
			CFG_TIMER_EN:    c_timer = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [7:0] peak, input logic [15:0] win,
		input bit g, input bit ta, input bit tm);
		write_reg(CFG_PEAK_HEIGHT, {8'd0, peak});
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_GESTURE_EN, {15'd0, g});
		write_reg(CFG_TARE_EN, {15'd0, ta});
		write_reg(CFG_TIMER_EN, {15'd0, tm});
		@(posedge clk) cfg_we <= 1'b0;
		@(negedge clk);
		n_phases++;
	endtask

	// maybe send random samples, settle on a level, tap a few times, then maybe let the decision expire
	task automatic gen_scenario();
		int level, h, thr, win, e, dt;
		thr = int'(c_peak) * 100;
		win = int'(c_win);
		case ($urandom_range(0, 9))
			0: level = 8388607 - 30000;
			1: level = -8388608 + 50;
			default: level = int'($urandom_range(0, 200000)) - 100000;
		endcase
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4))
				push_at(int'($urandom), $urandom, 1'($urandom_range(0, 1)));
		end
		repeat ($urandom_range(5, 7))
			push_sample(level + int'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 90 : 40)),
				$urandom_range(100, 160), $urandom_range(0, 9) != 0);
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 4) == 0)
				h = $urandom_range(250, thr + 300);
			else
				h = thr + int'($urandom_range(150, 1500));
			if (h < 250)
				h = 250;
			if ($urandom_range(0, 5) == 0)
				dt = $urandom_range(win / 2, win + 300);
			else
				dt = $urandom_range(5, win / 4 + 20);
			if ($urandom_range(0, 1) == 0)
				push_sample(level + int'($urandom_range(0, 40)), dt, $urandom_range(0, 9) != 0);
			push_sample(level + h, dt, $urandom_range(0, 9) != 0);
			if ($urandom_range(0, 7) == 0)
				push_sample(level + h - 100, $urandom_range(5, 60), $urandom_range(0, 9) != 0);
			push_sample(level + int'($urandom_range(0, 40)), $urandom_range(5, win / 4 + 20),
				$urandom_range(0, 9) != 0);
		end
		if ($urandom_range(0, 3) != 0) begin
			e = 0;
			while (e <= win) begin
				dt = (win / 3 > 100) ? $urandom_range(win / 3, win / 2 + 100)
					: $urandom_range(100, 300);
				push_sample(level + int'($urandom_range(0, 40)), dt, $urandom_range(0, 9) != 0);
				e += dt;
			end
		end
	endtask

	initial begin
		int phase, phase_start, n_directed;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_PEAK_HEIGHT;
		cfg_data  = '0;
		weight_ch.valid           = 1'b0;
		weight_ch.weight_cg       = '0;
		weight_ch.time_ms         = '0;
		weight_ch.scale_has_timer = 1'b0;
		gesture_ch.ready          = 1'b0;
		src_calm = 1'b0;
		rx_calm  = 1'b0;
		c_peak  = 8'd15;
		c_win   = WINDOW_RST;
		c_gest  = 1'b0;
		c_tare  = 1'b1;
		c_timer = 1'b1;
		foreach (hist_cg[i])
			hist_cg[i] = '0;
		h_idx = 0;
		h_fill = 0;
		last_store = '0;
		last_peak  = '0;
		dec_start  = '0;
		base_cg = '0;
		prev_cg = '0;
		rising = 1'b0;
		dec_open = 1'b0;
		peaks = 0;
		tmr_phase = '0;
		t_now = '0;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// extremes with the reset settings; history not yet full
		push_at(0, 32'd0, 1'b0);
		push_at(8388607, 32'hFFFF_FFFF, 1'b1);
		push_at(-8388608, 32'h0000_0063, 1'b0);
		drain();

		apply_config(8'd10, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		push_at(1000, 32'd1000, 1'b1);
		push_at(1010, 32'd1100, 1'b1);
		push_at(1020, 32'd1200, 1'b1);
		push_at(1030, 32'd1300, 1'b1);
		push_at(1040, 32'd1400, 1'b1);
		// first peak after reset, then second and third inside the window
		push_at(4000, 32'd1450, 1'b1);
		push_at(1000, 32'd1480, 1'b1);
		push_at(4000, 32'd1520, 1'b1);
		push_at(1000, 32'd1560, 1'b1);
		push_at(5000, 32'd1600, 1'b1);
		push_at(1000, 32'd1640, 1'b1);
		// double tap, then let the window run out for a tare
		push_at(4000, 32'd1700, 1'b1);
		push_at(1000, 32'd1740, 1'b1);
		push_at(4000, 32'd1800, 1'b1);
		push_at(1000, 32'd1840, 1'b1);
		push_at(1000, 32'd67375, 1'b0);
		// peak outside the window, then one too low to count
		push_at(4000, 32'd137375, 1'b1);
		push_at(1000, 32'd137400, 1'b1);
		push_at(1500, 32'd137500, 1'b1);
		push_at(1000, 32'd137550, 1'b1);
		drain();
		n_directed = n_pushed;

		phase = 0;
		while (n_pushed - n_directed < RAND_ITEMS) begin
			src_calm = ($urandom_range(0, 3) == 0);
			rx_calm  = ($urandom_range(0, 3) == 0);
			case (phase)
				0: apply_config(8'd0, 16'd0, 1'b1, 1'b1, 1'b1);
				1: apply_config(8'd255, 16'd1500, 1'b1, 1'b0, 1'b1);
				2: apply_config(8'd20, 16'd800, 1'b1, 1'b1, 1'b0);
				3: begin
					apply_config(8'($urandom_range(5, 40)), 16'hFFFF, 1'b1, 1'b1, 1'b1);
					t_now = 32'hFFFF_0000;
				end
				4: apply_config(8'($urandom_range(0, 60)), 16'($urandom_range(200, 1200)),
					1'b0, 1'b1, 1'b1);
				default: apply_config(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
						: $urandom_range(0, 40)),
					16'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(100, 2000)),
					$urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0,
					$urandom_range(0, 3) != 0);
			endcase
			phase_start = n_pushed;
			while (n_pushed - phase_start < 150 && n_pushed - n_directed < RAND_ITEMS)
				gen_scenario();
			drain();
			phase++;
		end

		repeat (40) @(posedge clk);
		$display("tb_top: %0d samples and %0d actions checked over %0d setting phases",
			n_taken, n_results, n_phases);
		$display("tb_top: %0d tare and %0d timer actions expected, %0d mismatches",
			n_tare, n_timer, n_errors);
		if (n_errors == 0 && pending_actions.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/stgd_pkg.sv
sv/stgd_in_if.sv
sv/stgd_out_if.sv
sv/stgd_ram.sv
sv/scale_tap_gesture_detector_top.sv
sim/tb_top.sv
